// ----- sv/tsle_pkg.sv -----
// Shared types and constants for the timed slot list engine.
package tsle_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int KW          = $clog2(MAX_RESULTS);
  localparam int QDEPTH      = 2;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SWEEP  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_REMOVED = 3'd2,
    KIND_REFUSED = 3'd3,
    KIND_UPDATE  = 3'd4,
    KIND_EXPIRED = 3'd5,
    KIND_EMPTY   = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_REM,
    S_ADD_WR,
    S_ADD_LINK,
    S_RM_RD,
    S_RM_DO,
    S_SW_HEAD,
    S_SW_RD,
    S_SW_DO
  } state_e;

  typedef struct packed {
    action_e     act;
    logic [31:0] now;
    logic [4:0]  par;
    logic [31:0] dur;
    logic [2:0]  strip;
    logic [7:0]  effect;
    logic [3:0]  target;
  } cmd_t;

endpackage

// ----- sv/tsle_front.sv -----
// Request front end: decode the action and queue work for the back end.
module tsle_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tsle_pkg::cmd_t  req_i,
  output logic            busy_o,
  output logic            cmd_valid_o,
  output tsle_pkg::cmd_t  cmd_o,
  input  logic            cmd_pop_i
);
  import tsle_pkg::*;

  cmd_t       fifo_q [QDEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign busy_o      = (cnt_q == 2'(QDEPTH));
  // drop requests with the unused action code: they produce nothing
  assign push        = start_i && !busy_o && (req_i.act != ACT_NONE);
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= req_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("push lost");

endmodule

// ----- sv/tsle_back.sv -----
// Slot table back end: record memories, free stack, linked order and sweep sequencer.
module tsle_back #(
  parameter int SLOTS = tsle_pkg::SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  tsle_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            strobe_o,
  output logic [2:0]      kind_o,
  output logic [3:0]      slot_o,
  output logic [31:0]     elapsed_o,
  output logic [31:0]     slot_duration_o,
  output logic [2:0]      slot_strip_o,
  output logic [7:0]      slot_effect_o,
  output logic [4:0]      slot_parent_o,
  output logic            last_o
);
  import tsle_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW:0] NIL = {1'b1, {IW{1'b0}}};

  // record memories
  logic [31:0] start_m [SLOTS];
  logic [31:0] dur_m   [SLOTS];
  logic [2:0]  strip_m [SLOTS];
  logic [7:0]  eff_m   [SLOTS];
  logic [4:0]  par_m   [SLOTS];
  logic [IW:0] prev_m  [SLOTS];
  logic [IW:0] next_m  [SLOTS];
  logic [IW-1:0] fs_m  [SLOTS];

  logic [31:0] start_rd, dur_rd;
  logic [2:0]  strip_rd;
  logic [7:0]  eff_rd;
  logic [4:0]  par_rd;
  logic [IW:0] prev_rd, next_rd;
  logic [IW-1:0] fs_rd;
  logic        fs_vld_rd;

  state_e      state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [IW:0] cur_q, cur_d, head_q, head_d, tail_q, tail_d;
  logic [IW:0] free_top_q, free_top_d;
  logic [KW-1:0] k_q, k_d;
  logic [31:0] rem_q, rem_d;
  logic [SLOTS-1:0] active_q, active_d, fs_vld_q, fs_vld_d;

  logic        out_vld_d, out_vld_q;
  kind_e       kind_d, kind_q;
  logic [3:0]  slot_d, slot_q;
  logic [31:0] el_d, el_q, sdur_d, sdur_q;
  logic [2:0]  sstrip_d, sstrip_q;
  logic [7:0]  seff_d, seff_q;
  logic [4:0]  spar_d, spar_q;
  logic        last_d, last_q;

  // memory ports
  logic [IW-1:0] rd_addr;
  logic          rec_we;
  logic [IW-1:0] rec_wa;
  logic [31:0]   rec_dur_wd;
  logic          next_we, prev_we, fs_we;
  logic [IW-1:0] next_wa, prev_wa, fs_wa;
  logic [IW:0]   next_wd, prev_wd;
  logic [IW-1:0] fs_wd;

  // shared datapath terms
  logic [IW-1:0] par_idx, tgt_idx, cur_idx, new_slot;
  logic          clip_en, refused, full, tail_nil;
  logic [31:0]   pel, el, dur_clip;
  logic          sw_last, sw_live;

  assign par_idx  = IW'(cmd_q.par[3:0]);
  assign tgt_idx  = IW'(cmd_q.target);
  assign cur_idx  = cur_q[IW-1:0];
  assign clip_en  = !cmd_q.par[4] && (cmd_q.par[3:0] != 4'd0)
                    && (32'(cmd_q.par[3:0]) < SLOTS);
  assign refused  = (32'(cmd_q.target) >= SLOTS) || !active_q[tgt_idx];
  assign full     = (32'(free_top_q) >= SLOTS);
  assign tail_nil = tail_q[IW];
  assign pel      = cmd_q.now - start_rd;
  assign el       = cmd_q.now - start_rd;
  assign dur_clip = (clip_en && (cmd_q.dur > rem_q)) ? rem_q : cmd_q.dur;
  assign new_slot = fs_vld_rd ? fs_rd : free_top_q[IW-1:0];
  assign sw_live  = (el < dur_rd);
  assign sw_last  = next_rd[IW] || (k_q == KW'(MAX_RESULTS - 1));
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.act)
            ACT_ADD:    state_d = S_ADD_RD;
            ACT_REMOVE: state_d = S_RM_RD;
            ACT_SWEEP:  state_d = S_SW_HEAD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD:   state_d = S_ADD_REM;
      S_ADD_REM:  state_d = full ? S_IDLE : S_ADD_WR;
      S_ADD_WR:   state_d = S_ADD_LINK;
      S_ADD_LINK: state_d = S_IDLE;
      S_RM_RD:    state_d = refused ? S_IDLE : S_RM_DO;
      S_RM_DO:    state_d = S_IDLE;
      S_SW_HEAD:  state_d = head_q[IW] ? S_IDLE : S_SW_RD;
      S_SW_RD:    state_d = S_SW_DO;
      S_SW_DO:    state_d = sw_last ? S_IDLE : S_SW_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d      = cmd_q;
    cur_d      = cur_q;
    head_d     = head_q;
    tail_d     = tail_q;
    free_top_d = free_top_q;
    k_d        = k_q;
    rem_d      = rem_q;
    active_d   = active_q;
    fs_vld_d   = fs_vld_q;
    rd_addr    = cur_idx;
    rec_we     = 1'b0;
    rec_wa     = cur_idx;
    rec_dur_wd = dur_clip;
    next_we    = 1'b0;
    next_wa    = cur_idx;
    next_wd    = NIL;
    prev_we    = 1'b0;
    prev_wa    = cur_idx;
    prev_wd    = tail_q;
    fs_we      = 1'b0;
    fs_wa      = IW'(free_top_q - 1'b1);
    fs_wd      = cur_idx;
    out_vld_d  = 1'b0;
    kind_d     = KIND_ADDED;
    slot_d     = 4'(cur_idx);
    el_d       = 32'd0;
    sdur_d     = 32'd0;
    sstrip_d   = 3'd0;
    seff_d     = 8'd0;
    spar_d     = 5'd0;
    last_d     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) cmd_d = cmd_i;
      end
      S_ADD_RD: rd_addr = par_idx;
      S_ADD_REM: begin
        // remaining parent time, zero once spent
        rem_d = (pel >= dur_rd) ? 32'd0 : dur_rd - pel;
        if (full) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_FULL;
          slot_d    = 4'd0;
        end
      end
      S_ADD_WR: begin
        cur_d      = {1'b0, new_slot};
        rem_d      = dur_clip;
        rec_we     = 1'b1;
        rec_wa     = new_slot;
        next_we    = 1'b1;
        next_wa    = new_slot;
        next_wd    = NIL;
        prev_we    = 1'b1;
        prev_wa    = new_slot;
        prev_wd    = tail_q;
      end
      S_ADD_LINK: begin
        if (tail_nil) head_d = cur_q;
        else begin
          next_we = 1'b1;
          next_wa = tail_q[IW-1:0];
          next_wd = cur_q;
        end
        tail_d            = cur_q;
        active_d[cur_idx] = 1'b1;
        free_top_d        = free_top_q + 1'b1;
        out_vld_d = 1'b1;
        kind_d    = KIND_ADDED;
        sdur_d    = rem_q;
        sstrip_d  = cmd_q.strip;
        seff_d    = cmd_q.effect;
        spar_d    = cmd_q.par;
      end
      S_RM_RD: begin
        rd_addr = tgt_idx;
        cur_d   = {1'b0, tgt_idx};
        if (refused) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_REFUSED;
          slot_d    = cmd_q.target;
        end
      end
      S_SW_HEAD: begin
        cur_d = head_q;
        k_d   = '0;
        if (head_q[IW]) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_EMPTY;
          slot_d    = 4'd0;
        end
      end
      S_SW_RD: rd_addr = cur_idx;
      S_RM_DO, S_SW_DO: begin
        out_vld_d = 1'b1;
        sdur_d    = dur_rd;
        sstrip_d  = strip_rd;
        seff_d    = eff_rd;
        spar_d    = par_rd;
        if (state_q == S_SW_DO && sw_live) begin
          kind_d = KIND_UPDATE;
          el_d   = el;
        end else begin
          kind_d = (state_q == S_RM_DO) ? KIND_REMOVED : KIND_EXPIRED;
          // unlink and push back on the free stack
          if (prev_rd[IW]) head_d = next_rd;
          else begin
            next_we = 1'b1;
            next_wa = prev_rd[IW-1:0];
            next_wd = next_rd;
          end
          if (next_rd[IW]) tail_d = prev_rd;
          else begin
            prev_we = 1'b1;
            prev_wa = next_rd[IW-1:0];
            prev_wd = prev_rd;
          end
          active_d[cur_idx] = 1'b0;
          if (free_top_q != '0) begin
            free_top_d      = free_top_q - 1'b1;
            fs_we           = 1'b1;
            fs_vld_d[fs_wa] = 1'b1;
          end
        end
        if (state_q == S_SW_DO) begin
          last_d = sw_last;
          cur_d  = next_rd;
          k_d    = k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= NIL;
      tail_q     <= NIL;
      free_top_q <= '0;
      active_q   <= '0;
      fs_vld_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      free_top_q <= free_top_d;
      active_q   <= active_d;
      fs_vld_q   <= fs_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    cur_q    <= cur_d;
    k_q      <= k_d;
    rem_q    <= rem_d;
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    el_q     <= el_d;
    sdur_q   <= sdur_d;
    sstrip_q <= sstrip_d;
    seff_q   <= seff_d;
    spar_q   <= spar_d;
    last_q   <= last_d;
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      start_m[rec_wa] <= cmd_q.now;
      dur_m[rec_wa]   <= rec_dur_wd;
      strip_m[rec_wa] <= cmd_q.strip;
      eff_m[rec_wa]   <= cmd_q.effect;
      par_m[rec_wa]   <= cmd_q.par;
    end
    if (next_we) next_m[next_wa] <= next_wd;
    if (prev_we) prev_m[prev_wa] <= prev_wd;
    if (fs_we)   fs_m[fs_wa]     <= fs_wd;
    start_rd  <= start_m[rd_addr];
    dur_rd    <= dur_m[rd_addr];
    strip_rd  <= strip_m[rd_addr];
    eff_rd    <= eff_m[rd_addr];
    par_rd    <= par_m[rd_addr];
    prev_rd   <= prev_m[rd_addr];
    next_rd   <= next_m[rd_addr];
    fs_rd     <= fs_m[free_top_q[IW-1:0]];
    fs_vld_rd <= fs_vld_q[free_top_q[IW-1:0]];
  end

  assign strobe_o        = out_vld_q;
  assign kind_o          = kind_q;
  assign slot_o          = slot_q;
  assign elapsed_o       = el_q;
  assign slot_duration_o = sdur_q;
  assign slot_strip_o    = sstrip_q;
  assign slot_effect_o   = seff_q;
  assign slot_parent_o   = spar_q;
  assign last_o          = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_q) == 32'(free_top_q))
    else $error("active count differs from free stack depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q[IW] == tail_q[IW])
    else $error("list head and tail disagree on emptiness");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_top_q == '0) == head_q[IW])
    else $error("empty list with slots in use");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW_DO && !sw_last) |=> (state_q == S_SW_RD))
    else $error("sweep walk stopped early");

endmodule

// ----- sv/timed_slot_list_engine_top.sv -----
// Top level of the timed slot list engine.
// A table of SLOTS timed slots driven by single requests: add, remove or sweep.
// A request is taken on a clock edge with start_i high and busy_o low; a
// two-entry queue sits between the request decoder and the slot sequencer, so
// busy_o rises only when two requests wait behind the one being worked on.
// Results leave on strobe_o, each valid for exactly one cycle, with last_o
// marking the final result of a request; the receiver cannot stall them.
// An add reads the parent, finds its remaining time, writes the record and
// links it (not when the table is full); a remove reads and unlinks the
// target (not when refused); a sweep fetches the head, then per visited slot
// does one registered read of the record memories. A sweep visits at most 16
// slots per request. The unused action code is taken and dropped.
module timed_slot_list_engine_top #(
  parameter int SLOTS = tsle_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] current_frame_i,
  input  logic signed [4:0] parent_slot_i,
  input  logic [31:0] duration_i,
  input  logic [2:0]  strip_id_i,
  input  logic [7:0]  effect_id_i,
  input  logic [3:0]  target_slot_i,
  output logic        strobe_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [31:0] elapsed_o,
  output logic [31:0] slot_duration_o,
  output logic [2:0]  slot_strip_o,
  output logic [7:0]  slot_effect_o,
  output logic signed [4:0] slot_parent_o,
  output logic        last_o
);
  import tsle_pkg::*;

  cmd_t req, cmd;
  logic cmd_valid, cmd_pop;

  // bundle the request fields
  always_comb begin
    req.act    = action_e'(action_i);
    req.now    = current_frame_i;
    req.par    = parent_slot_i;
    req.dur    = duration_i;
    req.strip  = strip_id_i;
    req.effect = effect_id_i;
    req.target = target_slot_i;
  end

  tsle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tsle_back #(.SLOTS(SLOTS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .strobe_o        (strobe_o),
    .kind_o          (kind_o),
    .slot_o          (slot_o),
    .elapsed_o       (elapsed_o),
    .slot_duration_o (slot_duration_o),
    .slot_strip_o    (slot_strip_o),
    .slot_effect_o   (slot_effect_o),
    .slot_parent_o   (slot_parent_o),
    .last_o          (last_o)
  );

endmodule
